// ===== rtl/core/ray_box_slab_intersection_top_assert.svh =====
// assertion macros for the ray box slab intersection block
`ifndef RAY_BOX_SLAB_INTERSECTION_TOP_ASSERT_SVH
`define RAY_BOX_SLAB_INTERSECTION_TOP_ASSERT_SVH

// same-cycle implication under synchronous reset
`define RBSI_ASSERT_SAME(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("rbsi same-cycle check failed");

// next-cycle implication under synchronous reset
`define RBSI_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("rbsi next-cycle check failed");

`endif

// ===== rtl/core/rbsi_pkg.sv =====
// shared widths and constants for the ray box slab intersection block
package rbsi_pkg;
   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS = 16;
   localparam int MAG_W = COORD_WIDTH + 1;
   localparam int NUM_W = MAG_W + FRAC_BITS;
   localparam int QUO_W = COORD_WIDTH + 1;
   localparam int DIV_LAT = QUO_W + 4;
   localparam int AXES = 3;
   localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
endpackage

// ===== rtl/core/rbsi_div.sv =====
// pipelined saturating slab quotient ((bound - origin) << frac) / dir, one bit per stage
module rbsi_div (
   input  logic                                   clock,
   input  logic                                   en,
   input  logic signed [rbsi_pkg::COORD_WIDTH-1:0] bound,
   input  logic signed [rbsi_pkg::COORD_WIDTH-1:0] origin,
   input  logic signed [rbsi_pkg::COORD_WIDTH-1:0] dir,
   output logic signed [rbsi_pkg::COORD_WIDTH-1:0] quot
);
   import rbsi_pkg::*;

   localparam logic [QUO_W-1:0] HALF = QUO_W'(1) << (COORD_WIDTH - 1);

   logic signed [MAG_W-1:0]       diff_ff;
   logic signed [COORD_WIDTH-1:0] dir0_ff;
   logic [MAG_W-1:0]              mag_ff;
   logic [COORD_WIDTH-1:0]        dm1_ff;
   logic                          neg1_ff;
   logic [NUM_W-1:0]              num;

   logic [COORD_WIDTH-1:0] rem_ff [0:QUO_W];
   logic [COORD_WIDTH-1:0] rem_in [1:QUO_W];
   logic [QUO_W-1:0]       low_ff [0:QUO_W];
   logic [QUO_W-1:0]       low_in [1:QUO_W];
   logic [QUO_W-1:0]       q_ff   [0:QUO_W];
   logic [QUO_W-1:0]       q_in   [1:QUO_W];
   logic [COORD_WIDTH-1:0] dm_ff  [0:QUO_W];
   logic                   neg_ff [0:QUO_W];
   logic                   ovf_ff [0:QUO_W];
   logic [COORD_WIDTH:0]   trial  [1:QUO_W];
   logic                   ge     [1:QUO_W];

   logic signed [COORD_WIDTH-1:0] quot_ff;
   logic signed [COORD_WIDTH-1:0] quot_in;

   assign num = {mag_ff, {FRAC_BITS{1'b0}}};

   always_comb begin
      for (int k = 1; k <= QUO_W; k++) begin
         trial[k] = {rem_ff[k-1], low_ff[k-1][QUO_W-1]};
         ge[k] = trial[k] >= {1'b0, dm_ff[k-1]};
         rem_in[k] = ge[k] ? COORD_WIDTH'(trial[k] - {1'b0, dm_ff[k-1]})
                           : COORD_WIDTH'(trial[k]);
         low_in[k] = low_ff[k-1] << 1;
         q_in[k] = {q_ff[k-1][QUO_W-2:0], ge[k]};
      end
   end

   always_comb begin
      if (neg_ff[QUO_W]) begin
         if (ovf_ff[QUO_W] || q_ff[QUO_W] > HALF) begin
            quot_in = COORD_MIN;
         end else begin
            quot_in = COORD_WIDTH'(-q_ff[QUO_W]);
         end
      end else begin
         if (ovf_ff[QUO_W] || q_ff[QUO_W] >= HALF) begin
            quot_in = COORD_MAX;
         end else begin
            quot_in = COORD_WIDTH'(q_ff[QUO_W]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         diff_ff <= {bound[COORD_WIDTH-1], bound} - {origin[COORD_WIDTH-1], origin};
         dir0_ff <= dir;
         mag_ff <= diff_ff[MAG_W-1] ? MAG_W'(-diff_ff) : MAG_W'(diff_ff);
         dm1_ff <= dir0_ff[COORD_WIDTH-1] ? COORD_WIDTH'(-dir0_ff) : COORD_WIDTH'(dir0_ff);
         neg1_ff <= diff_ff[MAG_W-1] ^ dir0_ff[COORD_WIDTH-1];
         rem_ff[0] <= COORD_WIDTH'(num[NUM_W-1:QUO_W]);
         low_ff[0] <= num[QUO_W-1:0];
         q_ff[0] <= '0;
         dm_ff[0] <= dm1_ff;
         neg_ff[0] <= neg1_ff;
         ovf_ff[0] <= COORD_WIDTH'(num[NUM_W-1:QUO_W]) >= dm1_ff;
         for (int k = 1; k <= QUO_W; k++) begin
            rem_ff[k] <= rem_in[k];
            low_ff[k] <= low_in[k];
            q_ff[k] <= q_in[k];
            dm_ff[k] <= dm_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
         end
         quot_ff <= quot_in;
      end
   end

   assign quot = quot_ff;
endmodule

// ===== rtl/core/ray_box_slab_intersection_top.sv =====
// top level of the ray versus axis-aligned box slab test
//
// one input transaction carries a box (min and max corners) and a ray (origin and
// direction), all signed q16.16; each produces exactly one result transaction with a
// hit flag and the entry distance (zero on a miss)
// the block keeps no state between transactions
// a new transaction is taken every cycle while req_stall is low, as the six
// dividers are pipelined bit per stage (33 quotient stages)
// the pipeline moves as one: while rsp_valid is high and rsp_stall is high every
// stage holds, req_stall is raised, and the waiting result does not change; while
// the output is empty or being taken, req_stall is low
// reset clears all valid bits, so rsp_valid drops in the cycle after reset;
// payload registers are not reset
// a zero direction component makes that axis unbounded if the origin lies between
// the bounds and forces a miss otherwise; quotients saturate to the 32-bit range
module ray_box_slab_intersection_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [rbsi_pkg::COORD_WIDTH-1:0] req_box_min_x,
   input  logic signed [rbsi_pkg::COORD_WIDTH-1:0] req_box_min_y,
   input  logic signed [rbsi_pkg::COORD_WIDTH-1:0] req_box_min_z,
   input  logic signed [rbsi_pkg::COORD_WIDTH-1:0] req_box_max_x,
   input  logic signed [rbsi_pkg::COORD_WIDTH-1:0] req_box_max_y,
   input  logic signed [rbsi_pkg::COORD_WIDTH-1:0] req_box_max_z,
   input  logic signed [rbsi_pkg::COORD_WIDTH-1:0] req_origin_x,
   input  logic signed [rbsi_pkg::COORD_WIDTH-1:0] req_origin_y,
   input  logic signed [rbsi_pkg::COORD_WIDTH-1:0] req_origin_z,
   input  logic signed [rbsi_pkg::COORD_WIDTH-1:0] req_dir_x,
   input  logic signed [rbsi_pkg::COORD_WIDTH-1:0] req_dir_y,
   input  logic signed [rbsi_pkg::COORD_WIDTH-1:0] req_dir_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_hit,
   output logic signed [rbsi_pkg::COORD_WIDTH-1:0] rsp_entry_distance
);
   import rbsi_pkg::*;

   logic en;

   logic signed [COORD_WIDTH-1:0] bmin [0:AXES-1];
   logic signed [COORD_WIDTH-1:0] bmax [0:AXES-1];
   logic signed [COORD_WIDTH-1:0] org  [0:AXES-1];
   logic signed [COORD_WIDTH-1:0] dirv [0:AXES-1];
   logic signed [COORD_WIDTH-1:0] qa   [0:AXES-1];
   logic signed [COORD_WIDTH-1:0] qb   [0:AXES-1];
   logic signed [MAG_W-1:0]       lo   [0:AXES-1];
   logic signed [MAG_W-1:0]       hi   [0:AXES-1];
   logic [AXES-1:0]               zero_now;
   logic [AXES-1:0]               ins_now;

   logic                  v_ff    [0:DIV_LAT-1];
   logic [AXES-1:0]       zero_ff [0:DIV_LAT-1];
   logic [AXES-1:0]       ins_ff  [0:DIV_LAT-1];

   logic signed [COORD_WIDTH-1:0] near_ff [0:AXES-1];
   logic signed [COORD_WIDTH-1:0] far_ff  [0:AXES-1];
   logic                          v_m_ff;
   logic                          ok_m_ff;

   logic signed [COORD_WIDTH-1:0] entry_ff;
   logic signed [COORD_WIDTH-1:0] exit_ff;
   logic signed [COORD_WIDTH-1:0] entry_in;
   logic signed [COORD_WIDTH-1:0] exit_in;
   logic                          v_e_ff;
   logic                          ok_e_ff;

   logic                          rsp_valid_ff;
   logic                          rsp_hit_ff;
   logic                          rsp_hit_in;
   logic signed [COORD_WIDTH-1:0] rsp_entry_ff;

   assign en = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   assign bmin[0] = req_box_min_x;
   assign bmin[1] = req_box_min_y;
   assign bmin[2] = req_box_min_z;
   assign bmax[0] = req_box_max_x;
   assign bmax[1] = req_box_max_y;
   assign bmax[2] = req_box_max_z;
   assign org[0]  = req_origin_x;
   assign org[1]  = req_origin_y;
   assign org[2]  = req_origin_z;
   assign dirv[0] = req_dir_x;
   assign dirv[1] = req_dir_y;
   assign dirv[2] = req_dir_z;

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         lo[a] = {bmin[a][COORD_WIDTH-1], bmin[a]} - {org[a][COORD_WIDTH-1], org[a]};
         hi[a] = {bmax[a][COORD_WIDTH-1], bmax[a]} - {org[a][COORD_WIDTH-1], org[a]};
         zero_now[a] = dirv[a] == '0;
         ins_now[a] = (lo[a] <= 0 && hi[a] >= 0) || (hi[a] <= 0 && lo[a] >= 0);
      end
   end

   for (genvar g = 0; g < AXES; g++) begin : g_axis
      rbsi_div u_div_min (
         .clock  (clock),
         .en     (en),
         .bound  (bmin[g]),
         .origin (org[g]),
         .dir    (dirv[g]),
         .quot   (qa[g])
      );
      rbsi_div u_div_max (
         .clock  (clock),
         .en     (en),
         .bound  (bmax[g]),
         .origin (org[g]),
         .dir    (dirv[g]),
         .quot   (qb[g])
      );
   end

   // valid bits ride alongside the dividers, as do the zero-direction and inside flags below
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_LAT; k++) begin
            v_ff[k] <= 1'b0;
         end
         v_m_ff <= 1'b0;
         v_e_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v_ff[0] <= req_valid;
         for (int k = 1; k < DIV_LAT; k++) begin
            v_ff[k] <= v_ff[k-1];
         end
         v_m_ff <= v_ff[DIV_LAT-1];
         v_e_ff <= v_m_ff;
         rsp_valid_ff <= v_e_ff;
      end
   end

   always_comb begin
      entry_in = near_ff[0];
      exit_in = far_ff[0];
      for (int a = 1; a < AXES; a++) begin
         if (near_ff[a] > entry_in) begin
            entry_in = near_ff[a];
         end
         if (far_ff[a] < exit_in) begin
            exit_in = far_ff[a];
         end
      end
   end

   assign rsp_hit_in = ok_e_ff && !(exit_ff < 0) && !(entry_ff > exit_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff[0] <= zero_now;
         ins_ff[0] <= ins_now;
         for (int k = 1; k < DIV_LAT; k++) begin
            zero_ff[k] <= zero_ff[k-1];
            ins_ff[k] <= ins_ff[k-1];
         end
         ok_m_ff <= &(~zero_ff[DIV_LAT-1] | ins_ff[DIV_LAT-1]);
         for (int a = 0; a < AXES; a++) begin
            if (zero_ff[DIV_LAT-1][a]) begin
               near_ff[a] <= COORD_MIN;
               far_ff[a] <= COORD_MAX;
            end else if (qa[a] < qb[a]) begin
               near_ff[a] <= qa[a];
               far_ff[a] <= qb[a];
            end else begin
               near_ff[a] <= qb[a];
               far_ff[a] <= qa[a];
            end
         end
         entry_ff <= entry_in;
         exit_ff <= exit_in;
         ok_e_ff <= ok_m_ff;
         rsp_hit_ff <= rsp_hit_in;
         rsp_entry_ff <= rsp_hit_in ? entry_ff : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit = rsp_hit_ff;
   assign rsp_entry_distance = rsp_entry_ff;

`include "ray_box_slab_intersection_top_assert.svh"

   `RBSI_ASSERT_SAME(a_miss_zero, clock, reset, rsp_valid && !rsp_hit, rsp_entry_distance == '0)
   `RBSI_ASSERT_NEXT(a_last_stage_moves, clock, reset, en && v_e_ff, rsp_valid)
   `RBSI_ASSERT_NEXT(a_hold_on_stall, clock, reset, rsp_valid && rsp_stall, $stable(v_e_ff))

endmodule
